>>> rtl/rpvt_pkg.sv
// Shared constants, register codes, pipeline tag type and arctangent table
// for the regular polygon vertex transform. No dependencies.
`default_nettype none

package rpvt_pkg;

  // Datapath widths
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int STAGE_W       = $clog2(CORDIC_STAGES);
  localparam int COUNT_W       = 9;
  localparam int RADIUS_W      = 16;
  localparam int ROT_W         = 16;
  localparam int SCALE_W       = 24;
  localparam int POS_W         = 16;
  localparam int GAIN_W        = 30;
  localparam int Z_W           = 32;
  localparam int XY_W          = 34;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 24;

  // Divider cells, angle stage, CORDIC cells, two output stages
  localparam int LATENCY = ANGLE_BITS + CORDIC_STAGES + 3;

  // CORDIC gain 0.60725... in Q30
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd6;

  // Side information that rides along with each transaction
  typedef struct packed {
    logic valid;
    logic last;
    logic err;
    logic flip;
  } tag_t;

  // atan(2^-i) in 32-bit turn units
  localparam logic [Z_W-1:0] ATAN_TURNS [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

`default_nettype wire

>>> rtl/rpvt_div_cell.sv
// One restoring-division cell: produces one quotient bit of index * 2^16 / count.
// Depends on rpvt_pkg.
`default_nettype none

module rpvt_div_cell (
  input  wire                              clk,
  input  wire                              rst_n,
  input  rpvt_pkg::tag_t                   tag_i,
  input  wire [rpvt_pkg::COUNT_W-1:0]      rem_i,
  input  wire [rpvt_pkg::ANGLE_BITS-1:0]   quo_i,
  input  wire [rpvt_pkg::COUNT_W-1:0]      den_i,
  output rpvt_pkg::tag_t                   tag_o,
  output logic [rpvt_pkg::COUNT_W-1:0]     rem_o,
  output logic [rpvt_pkg::ANGLE_BITS-1:0]  quo_o
);

  rpvt_pkg::tag_t                   tag_r;
  logic [rpvt_pkg::COUNT_W-1:0]     rem_r, rem_nxt;
  logic [rpvt_pkg::ANGLE_BITS-1:0]  quo_r, quo_nxt;
  logic [rpvt_pkg::COUNT_W:0]       rem_dbl;
  logic [rpvt_pkg::COUNT_W:0]       rem_diff;
  logic                             ge;

  always_comb begin
    rem_dbl  = {rem_i, 1'b0};
    rem_diff = rem_dbl - {1'b0, den_i};
    ge       = (rem_dbl >= {1'b0, den_i});
    rem_nxt  = ge ? rem_diff[rpvt_pkg::COUNT_W-1:0] : rem_dbl[rpvt_pkg::COUNT_W-1:0];
    quo_nxt  = {quo_i[rpvt_pkg::ANGLE_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign tag_o = tag_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule

`default_nettype wire

>>> rtl/rpvt_cordic_cell.sv
// One CORDIC rotation cell: shift-add step on x, y and residual angle z.
// Depends on rpvt_pkg for widths and the arctangent table.
`default_nettype none

module rpvt_cordic_cell (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire [rpvt_pkg::STAGE_W-1:0]           stage_i,
  input  rpvt_pkg::tag_t                        tag_i,
  input  wire signed [rpvt_pkg::XY_W-1:0]       x_i,
  input  wire signed [rpvt_pkg::XY_W-1:0]       y_i,
  input  wire signed [rpvt_pkg::Z_W-1:0]        z_i,
  output rpvt_pkg::tag_t                        tag_o,
  output logic signed [rpvt_pkg::XY_W-1:0]      x_o,
  output logic signed [rpvt_pkg::XY_W-1:0]      y_o,
  output logic signed [rpvt_pkg::Z_W-1:0]       z_o
);

  rpvt_pkg::tag_t                    tag_r;
  logic signed [rpvt_pkg::XY_W-1:0]  x_r, x_nxt, y_r, y_nxt, dx, dy;
  logic signed [rpvt_pkg::Z_W-1:0]   z_r, z_nxt, atan;
  logic [4:0]                        tab_idx;

  always_comb begin
    tab_idx = 5'(stage_i);
    atan    = $signed(rpvt_pkg::ATAN_TURNS[tab_idx]);
    dx      = y_i >>> stage_i;
    dy      = x_i >>> stage_i;
    // rotate toward zero residual angle
    if (z_i >= 0) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - atan;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + atan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign tag_o = tag_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

`default_nettype wire

>>> rtl/rpvt_out.sv
// Output stages: quadrant flip, per-axis scale multiply, round, centre add,
// saturation and error masking. Depends on rpvt_pkg.
`default_nettype none

module rpvt_out (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  rpvt_pkg::tag_t                        tag_i,
  input  wire signed [rpvt_pkg::XY_W-1:0]       x_i,
  input  wire signed [rpvt_pkg::XY_W-1:0]       y_i,
  input  wire [rpvt_pkg::SCALE_W-1:0]           scale_x,
  input  wire [rpvt_pkg::SCALE_W-1:0]           scale_y,
  input  wire signed [rpvt_pkg::POS_W-1:0]      center_x,
  input  wire signed [rpvt_pkg::POS_W-1:0]      center_y,
  output logic                                  valid,
  output logic signed [rpvt_pkg::POS_W-1:0]     pos_x,
  output logic signed [rpvt_pkg::POS_W-1:0]     pos_y,
  output logic                                  is_last,
  output logic                                  index_error,
  output logic                                  saturated
);

  localparam int PROD_W = rpvt_pkg::XY_W + rpvt_pkg::SCALE_W + 1;
  localparam int SH_W   = PROD_W - 24;
  localparam int SUM_W  = SH_W + 1;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = {{(PROD_W-24){1'b0}}, 1'b1, 23'b0};
  localparam logic signed [SUM_W-1:0]  POS_MAX    = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0]  POS_MIN    = -SUM_W'(32768);

  rpvt_pkg::tag_t                    tag_a_r, tag_b_r;
  logic signed [rpvt_pkg::XY_W-1:0]  cx, cy;
  logic signed [rpvt_pkg::SCALE_W:0] sx, sy;
  logic signed [PROD_W-1:0]          prod_x_r, prod_x_nxt, prod_y_r, prod_y_nxt;
  logic signed [PROD_W-1:0]          rnd_x, rnd_y;
  logic signed [SUM_W-1:0]           sum_x, sum_y;
  logic signed [rpvt_pkg::POS_W-1:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic                              hit_x, hit_y;
  logic                              last_r, last_nxt, err_r, sat_r, sat_nxt;

  // Stage A: undo the half-turn fold, then scale
  always_comb begin
    cx         = tag_i.flip ? -x_i : x_i;
    cy         = tag_i.flip ? -y_i : y_i;
    sx         = $signed({1'b0, scale_x});
    sy         = $signed({1'b0, scale_y});
    prod_x_nxt = cx * sx;
    prod_y_nxt = cy * sy;
  end

  // Stage B: round to Q14, add centre, clip
  always_comb begin
    rnd_x = prod_x_r + ROUND_HALF;
    rnd_y = prod_y_r + ROUND_HALF;
    sum_x = SUM_W'($signed(rnd_x[PROD_W-1:24])) + SUM_W'(center_x);
    sum_y = SUM_W'($signed(rnd_y[PROD_W-1:24])) + SUM_W'(center_y);
    hit_x = 1'b0;
    hit_y = 1'b0;
    if (sum_x > POS_MAX) begin
      pos_x_nxt = 16'sh7FFF;
      hit_x     = 1'b1;
    end else if (sum_x < POS_MIN) begin
      pos_x_nxt = 16'sh8000;
      hit_x     = 1'b1;
    end else begin
      pos_x_nxt = sum_x[rpvt_pkg::POS_W-1:0];
    end
    if (sum_y > POS_MAX) begin
      pos_y_nxt = 16'sh7FFF;
      hit_y     = 1'b1;
    end else if (sum_y < POS_MIN) begin
      pos_y_nxt = 16'sh8000;
      hit_y     = 1'b1;
    end else begin
      pos_y_nxt = sum_y[rpvt_pkg::POS_W-1:0];
    end
    // an index error zeroes the coordinates, is_last and saturated; valid and the error flag stay
    if (tag_a_r.err) begin
      pos_x_nxt = '0;
      pos_y_nxt = '0;
    end
    sat_nxt  = (hit_x | hit_y) & ~tag_a_r.err;
    last_nxt = tag_a_r.last & ~tag_a_r.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
    end else begin
      tag_a_r <= tag_i;
      tag_b_r <= tag_a_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_x_r <= prod_x_nxt;
    prod_y_r <= prod_y_nxt;
    pos_x_r  <= pos_x_nxt;
    pos_y_r  <= pos_y_nxt;
    last_r   <= last_nxt;
    err_r    <= tag_a_r.err;
    sat_r    <= sat_nxt;
  end

  assign valid       = tag_b_r.valid;
  assign pos_x       = pos_x_r;
  assign pos_y       = pos_y_r;
  assign is_last     = last_r;
  assign index_error = err_r;
  assign saturated   = sat_r;

endmodule

`default_nettype wire

>>> rtl/regular_polygon_vertex_transform.sv
// Top level of the regular polygon vertex transform: configuration registers,
// divider cell chain, angle stage, CORDIC cell chain and output stages.
// Depends on rpvt_pkg, rpvt_div_cell, rpvt_cordic_cell and rpvt_out.
//
// Usage
//   Input channel: drive in_vertex_index and raise start; a transaction is
//   taken at every rising edge with start high and busy low. The pipeline
//   never stalls, so busy stays low and one vertex can enter every cycle.
//   Result channel: out_valid is high for exactly one cycle per transaction,
//   with pos_x, pos_y (signed Q2.14), is_last, index_error and saturated.
//   Results leave in the order the indices entered. The receiver cannot
//   hold results off, and there is nothing in the block to hold them.
//   Pipeline: 35 register stages (16 divider cells, one angle stage,
//   16 CORDIC cells, two output stages). Throughput: one vertex per cycle,
//   set by the fully unrolled divider and CORDIC cell chains.
//   Configuration: cfg_we, cfg_index, cfg_data write one register per edge;
//   write only while no transaction is in flight. Unknown indexes are ignored.
//   Reset (rst_n low, synchronous): drop every transaction in flight and
//   load the register defaults (3 vertices, radius 120, unit scale, origin).
`default_nettype none

module regular_polygon_vertex_transform (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // input channel
  input  wire                                   start,
  output logic                                  busy,
  input  wire [rpvt_pkg::COUNT_W-1:0]           in_vertex_index,
  // result channel
  output logic                                  out_valid,
  output logic signed [rpvt_pkg::POS_W-1:0]     out_pos_x,
  output logic signed [rpvt_pkg::POS_W-1:0]     out_pos_y,
  output logic                                  out_is_last,
  output logic                                  out_index_error,
  output logic                                  out_saturated,
  // configuration port
  input  wire                                   cfg_we,
  input  wire [rpvt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [rpvt_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int AB = rpvt_pkg::ANGLE_BITS;
  localparam int CS = rpvt_pkg::CORDIC_STAGES;
  localparam logic signed [rpvt_pkg::Z_W-1:0] QUARTER = 32'sh40000000;
  localparam logic signed [rpvt_pkg::Z_W-1:0] HALF    = 32'sh80000000;
  localparam int XP_W = rpvt_pkg::RADIUS_W + rpvt_pkg::GAIN_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [rpvt_pkg::COUNT_W-1:0]         vertex_count_r;
  logic [rpvt_pkg::RADIUS_W-1:0]        radius_r;
  logic [rpvt_pkg::ROT_W-1:0]           rotation_r;
  logic [rpvt_pkg::SCALE_W-1:0]         scale_x_r, scale_y_r;
  logic signed [rpvt_pkg::POS_W-1:0]    center_x_r, center_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= 9'd3;
      radius_r       <= 16'd120;
      rotation_r     <= '0;
      scale_x_r      <= 24'd4194304;
      scale_y_r      <= 24'd4194304;
      center_x_r     <= '0;
      center_y_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rpvt_pkg::REG_VERTEX_COUNT: vertex_count_r <= cfg_data[rpvt_pkg::COUNT_W-1:0];
        rpvt_pkg::REG_RADIUS:       radius_r       <= cfg_data[rpvt_pkg::RADIUS_W-1:0];
        rpvt_pkg::REG_ROTATION:     rotation_r     <= cfg_data[rpvt_pkg::ROT_W-1:0];
        rpvt_pkg::REG_SCALE_X:      scale_x_r      <= cfg_data;
        rpvt_pkg::REG_SCALE_Y:      scale_y_r      <= cfg_data;
        rpvt_pkg::REG_CENTER_X:     center_x_r     <= $signed(cfg_data[rpvt_pkg::POS_W-1:0]);
        rpvt_pkg::REG_CENTER_Y:     center_y_r     <= $signed(cfg_data[rpvt_pkg::POS_W-1:0]);
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // The pipeline never holds back a transaction.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Entry: classify the index, start the divider chain with rem = index
  // ---------------------------------------------------------------------
  rpvt_pkg::tag_t                   tag_div [0:AB];
  logic [rpvt_pkg::COUNT_W-1:0]     rem_div [0:AB];
  logic [AB-1:0]                    quo_div [0:AB];

  always_comb begin
    tag_div[0].valid = start & ~busy;
    tag_div[0].err   = (vertex_count_r == '0) || (in_vertex_index >= vertex_count_r);
    tag_div[0].last  = (vertex_count_r != '0) &&
                       (in_vertex_index == vertex_count_r - rpvt_pkg::COUNT_W'(1));
    tag_div[0].flip  = 1'b0;
    rem_div[0]       = in_vertex_index;
    quo_div[0]       = '0;
  end

  // One quotient bit per cell: angle = floor(index * 2^AB / count)
  for (genvar i = 0; i < AB; i++) begin : g_div
    rpvt_div_cell u_div_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tag_i (tag_div[i]),
      .rem_i (rem_div[i]),
      .quo_i (quo_div[i]),
      .den_i (vertex_count_r),
      .tag_o (tag_div[i+1]),
      .rem_o (rem_div[i+1]),
      .quo_o (quo_div[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Angle stage: add rotation, fold into +/- quarter turn, form x0
  // ---------------------------------------------------------------------
  rpvt_pkg::tag_t                    tag_ang_r, tag_ang_nxt;
  logic signed [rpvt_pkg::Z_W-1:0]   z_ang_r, z_ang_nxt, z_raw;
  logic signed [rpvt_pkg::XY_W-1:0]  x_ang_r, x_ang_nxt;
  logic [XP_W-1:0]                   x0_prod;
  logic [XP_W:0]                     x0_rnd;

  always_comb begin
    z_raw       = $signed({quo_div[AB], {(rpvt_pkg::Z_W-AB){1'b0}}} +
                          {rotation_r, {(rpvt_pkg::Z_W-rpvt_pkg::ROT_W){1'b0}}});
    tag_ang_nxt = tag_div[AB];
    if (z_raw > QUARTER) begin
      z_ang_nxt        = z_raw - HALF;
      tag_ang_nxt.flip = 1'b1;
    end else if (z_raw < -QUARTER) begin
      z_ang_nxt        = z_raw + HALF;
      tag_ang_nxt.flip = 1'b1;
    end else begin
      z_ang_nxt        = z_raw;
      tag_ang_nxt.flip = 1'b0;
    end
    // radius times CORDIC gain, rounded from Q30 to Q16
    x0_prod   = XP_W'(radius_r) * XP_W'(rpvt_pkg::GAIN_Q30);
    x0_rnd    = {1'b0, x0_prod} + (XP_W+1)'(8192);
    x_ang_nxt = $signed(rpvt_pkg::XY_W'(x0_rnd[XP_W:14]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_ang_r <= '0;
    end else begin
      tag_ang_r <= tag_ang_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_ang_r <= z_ang_nxt;
    x_ang_r <= x_ang_nxt;
  end

  // ---------------------------------------------------------------------
  // CORDIC cell chain
  // ---------------------------------------------------------------------
  rpvt_pkg::tag_t                    tag_cor [0:CS];
  logic signed [rpvt_pkg::XY_W-1:0]  x_cor [0:CS];
  logic signed [rpvt_pkg::XY_W-1:0]  y_cor [0:CS];
  logic signed [rpvt_pkg::Z_W-1:0]   z_cor [0:CS];

  assign tag_cor[0] = tag_ang_r;
  assign x_cor[0]   = x_ang_r;
  assign y_cor[0]   = '0;
  assign z_cor[0]   = z_ang_r;

  for (genvar s = 0; s < CS; s++) begin : g_cordic
    rpvt_cordic_cell u_cordic_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stage_i (rpvt_pkg::STAGE_W'(s)),
      .tag_i   (tag_cor[s]),
      .x_i     (x_cor[s]),
      .y_i     (y_cor[s]),
      .z_i     (z_cor[s]),
      .tag_o   (tag_cor[s+1]),
      .x_o     (x_cor[s+1]),
      .y_o     (y_cor[s+1]),
      .z_o     (z_cor[s+1])
    );
  end

  // ---------------------------------------------------------------------
  // Scale, centre, saturate
  // ---------------------------------------------------------------------
  rpvt_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .tag_i       (tag_cor[CS]),
    .x_i         (x_cor[CS]),
    .y_i         (y_cor[CS]),
    .scale_x     (scale_x_r),
    .scale_y     (scale_y_r),
    .center_x    (center_x_r),
    .center_y    (center_y_r),
    .valid       (out_valid),
    .pos_x       (out_pos_x),
    .pos_y       (out_pos_y),
    .is_last     (out_is_last),
    .index_error (out_index_error),
    .saturated   (out_saturated)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, rpvt_pkg::LATENCY))
    else $error("result without a matching input transaction");

  a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_index_error) |->
      (out_pos_x == '0 && out_pos_y == '0 && !out_is_last && !out_saturated))
    else $error("index error result carries nonzero fields");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_pos_x == 16'sh7FFF || out_pos_x == 16'sh8000 ||
       out_pos_y == 16'sh7FFF || out_pos_y == 16'sh8000))
    else $error("saturated flag set with no coordinate at a limit");

  a_last_not_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_last && out_index_error))
    else $error("last vertex flagged as index error");

endmodule

`default_nettype wire
